// File: src/scr_pkg.sv
// Shared types, widths, constants and arithmetic helpers of the sphere collision block.
`default_nettype none
package scr_pkg;

  // Active axes (2 or 3); axes beyond it pass through unchanged
  localparam int DIM = 3;

  // Pipeline depths of the iterative units
  localparam int ISQ_STEPS = 32;                    // one root bit per stage
  localparam int DIV_STEPS = 31;                    // one quotient bit per stage
  localparam int SIDE_LAT  = ISQ_STEPS + DIV_STEPS; // sideband delay length

  // Radicand, root, normalized magnitude and divisor widths
  localparam int SQ_W   = 64;
  localparam int ROOT_W = 32;
  localparam int MN_W   = 31;

  // Reset values of the configuration registers
  localparam logic [30:0] RADIUS_RST = 31'd65536;
  localparam logic [17:0] ELAST_RST  = 18'd65536;

  // Reciprocal of ten, used as (y * RECIP10) >> RECIP10_SH for 32-bit y
  localparam logic [31:0] RECIP10    = 32'hCCCCCCCD;
  localparam int          RECIP10_SH = 35;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_CENTER_X   = 3'd0,
    CFG_CENTER_Y   = 3'd1,
    CFG_CENTER_Z   = 3'd2,
    CFG_RADIUS     = 3'd3,
    CFG_ELASTICITY = 3'd4
  } cfg_idx_t;

  // Per-item sideband that travels alongside the datapath
  typedef struct packed {
    logic             vld;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0]       dneg;
    logic [30:0]      rad;
    logic             hit;
    logic             nz;
    logic [2:0][30:0] mn;
  } scr_side_t;

  // Round to nearest, ties away from zero, after a right shift by s
  function automatic logic signed [71:0] rnd_sh(input logic signed [71:0] x,
                                                input logic [6:0] s);
    logic [71:0] mag;
    logic [71:0] m;
    mag = x[71] ? 72'(-x) : 72'(x);
    m   = (mag + (72'(1) << (s - 7'd1))) >> s;
    return x[71] ? -$signed(m) : $signed(m);
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [71:0] x);
    logic signed [71:0] hi;
    logic signed [71:0] lo;
    hi = 72'sd2147483647;
    lo = -72'sd2147483648;
    if (x > hi) begin
      return 32'h7FFFFFFF;
    end else if (x < lo) begin
      return 32'h80000000;
    end else begin
      return x[31:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: src/sphere_collision_response.sv
// Top level: particle against static sphere, bounce and push-out, fully pipelined.
//
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_ready    | pos_x..z, vel_x..z, node_radius
//  out_    | output    | out_valid / out_ready  | new_pos_x..z, new_vel_x..z, hit
//  cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One beat per cycle in and out when not stalled; depth is set by the 32-stage
// square root and the 31-stage normal divider between the front and back stages.
// Synchronous active-low reset clears all valid bits and resets the config regs.
// A stalled output beat freezes the whole pipeline; nothing is dropped or repeated.
// cfg_ready is high out of reset; a write takes effect at the next edge.
`default_nettype none
module sphere_collision_response (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [31:0] in_pos_x,
  input  wire  [31:0] in_pos_y,
  input  wire  [31:0] in_pos_z,
  input  wire  [31:0] in_vel_x,
  input  wire  [31:0] in_vel_y,
  input  wire  [31:0] in_vel_z,
  input  wire  [30:0] in_node_radius,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_new_pos_x,
  output logic [31:0] out_new_pos_y,
  output logic [31:0] out_new_pos_z,
  output logic [31:0] out_new_vel_x,
  output logic [31:0] out_new_vel_y,
  output logic [31:0] out_new_vel_z,
  output logic        out_hit,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [31:0] cfg_data
);
  import scr_pkg::*;

  // Configuration registers
  logic [31:0] cen_r [3];
  logic [30:0] rad_r;
  logic [17:0] elas_r;

  // Pipeline advance
  logic en;

  // Stage registers
  scr_side_t   a_s_r, b_s_r, c_s_r, d_s_r, e_s_r, f_s_r, g_s_r, h_s_r, i_s_r, j_s_r;
  scr_side_t   a_s_nxt, c_s_nxt;
  logic [32:0] a_m_r [3];
  logic [32:0] a_m_nxt [3];
  logic [31:0] a_rs_r;
  logic [32:0] b_m_r [3];
  logic [64:0] b_sq_r [3];
  logic [63:0] b_rr_r;
  logic [32:0] b_maxm_r;
  logic [32:0] b_maxm_nxt;
  logic [61:0] d_sqm_r [3];
  logic [63:0] e_sum_r;
  scr_side_t   dly_r [SIDE_LAT];

  logic [ROOT_W-1:0] len;
  logic [MN_W-1:0]   quo [3];

  logic signed [31:0] f_n_r [3];
  logic signed [63:0] f_pv_r [3];
  logic [61:0]        f_pm_r [3];
  logic signed [31:0] g_n_r [3];
  logic signed [33:0] g_dot_r;
  logic [31:0]        g_y_r [3];
  logic signed [65:0] h_dn_r [3];
  logic [31:0]        h_push_r [3];
  logic signed [35:0] i_v2_r [3];
  logic signed [33:0] i_np_r [3];
  logic signed [54:0] j_ve_r [3];
  logic signed [33:0] j_np_r [3];

  logic        out_valid_r;
  logic [31:0] opos_r [3];
  logic [31:0] ovel_r [3];
  logic        ohit_r;

  logic [31:0] in_pos [3];
  logic [31:0] in_vel [3];

  assign in_pos[0] = in_pos_x;
  assign in_pos[1] = in_pos_y;
  assign in_pos[2] = in_pos_z;
  assign in_vel[0] = in_vel_x;
  assign in_vel[1] = in_vel_y;
  assign in_vel[2] = in_vel_z;

  assign en        = out_ready || !out_valid_r;
  assign in_ready  = en && rst_n;
  assign cfg_ready = rst_n;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cen_r[0] <= '0;
      cen_r[1] <= '0;
      cen_r[2] <= '0;
      rad_r    <= RADIUS_RST;
      elas_r   <= ELAST_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CENTER_X:   cen_r[0] <= cfg_data;
        CFG_CENTER_Y:   cen_r[1] <= cfg_data;
        CFG_CENTER_Z:   cen_r[2] <= cfg_data;
        CFG_RADIUS:     rad_r    <= cfg_data[30:0];
        CFG_ELASTICITY: elas_r   <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  // Stage A: offset from the center and its magnitude
  always_comb begin
    logic signed [32:0] d;
    a_s_nxt     = '0;
    a_s_nxt.vld = in_valid;
    a_s_nxt.rad = in_node_radius;
    for (int i = 0; i < 3; i++) begin
      a_s_nxt.pos[i] = in_pos[i];
      a_s_nxt.vel[i] = in_vel[i];
      d = $signed({in_pos[i][31], in_pos[i]}) - $signed({cen_r[i][31], cen_r[i]});
      if (i < DIM) begin
        a_s_nxt.dneg[i] = d[32];
        a_m_nxt[i]      = d[32] ? 33'(-d) : 33'(d);
      end else begin
        a_s_nxt.dneg[i] = 1'b0;
        a_m_nxt[i]      = '0;
      end
    end
  end

  // Stage B: squares and the largest magnitude
  always_comb begin
    b_maxm_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      if (a_m_r[i] > b_maxm_nxt) begin
        b_maxm_nxt = a_m_r[i];
      end
    end
  end

  // Stage C: hit test and normalization of the magnitudes
  always_comb begin
    logic [66:0] sum;
    logic [5:0]  p;
    logic [63:0] sh;
    sum = 67'(b_sq_r[0]) + 67'(b_sq_r[1]) + 67'(b_sq_r[2]);
    p   = '0;
    for (int k = 0; k < 33; k++) begin
      if (b_maxm_r[k]) begin
        p = 6'(k);
      end
    end
    c_s_nxt     = b_s_r;
    c_s_nxt.hit = (sum <= 67'(b_rr_r));
    c_s_nxt.nz  = (b_maxm_r != '0);
    for (int i = 0; i < 3; i++) begin
      if (p > 6'd30) begin
        sh = 64'(b_m_r[i]) >> (p - 6'd30);
      end else begin
        sh = 64'(b_m_r[i]) << (6'd30 - p);
      end
      c_s_nxt.mn[i] = sh[MN_W-1:0];
    end
  end

  // Front stages A..E
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_s_r <= '0;
      b_s_r <= '0;
      c_s_r <= '0;
      d_s_r <= '0;
      e_s_r <= '0;
    end else if (en) begin
      a_s_r <= a_s_nxt;
      b_s_r <= a_s_r;
      c_s_r <= c_s_nxt;
      d_s_r <= c_s_r;
      e_s_r <= d_s_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_rs_r   <= {1'b0, rad_r} + {1'b0, in_node_radius};
      b_rr_r   <= a_rs_r * a_rs_r;
      b_maxm_r <= b_maxm_nxt;
      for (int i = 0; i < 3; i++) begin
        a_m_r[i]   <= a_m_nxt[i];
        b_m_r[i]   <= a_m_r[i];
        b_sq_r[i]  <= 65'(66'(a_m_r[i]) * 66'(a_m_r[i]));
        d_sqm_r[i] <= 62'(c_s_r.mn[i]) * 62'(c_s_r.mn[i]);
      end
      e_sum_r <= 64'(d_sqm_r[0]) + 64'(d_sqm_r[1]) + 64'(d_sqm_r[2]);
    end
  end

  // Sideband delay across the root and divider pipelines
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SIDE_LAT; k++) begin
        dly_r[k] <= '0;
      end
    end else if (en) begin
      dly_r[0] <= e_s_r;
      for (int k = 1; k < SIDE_LAT; k++) begin
        dly_r[k] <= dly_r[k-1];
      end
    end
  end

  scr_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .x    (e_sum_r),
    .root (len)
  );

  for (genvar g = 0; g < 3; g++) begin : g_div
    scr_div u_div (
      .clk (clk),
      .en  (en),
      .num (dly_r[ISQ_STEPS-1].mn[g]),
      .den (len),
      .quo (quo[g])
    );
  end

  // Back stages F..J: dot product, reflection, push-out, elasticity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_s_r <= '0;
      g_s_r <= '0;
      h_s_r <= '0;
      i_s_r <= '0;
      j_s_r <= '0;
    end else if (en) begin
      f_s_r <= dly_r[SIDE_LAT-1];
      g_s_r <= f_s_r;
      h_s_r <= g_s_r;
      i_s_r <= h_s_r;
      j_s_r <= i_s_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [31:0] nq;
    logic signed [65:0] pvs;
    logic signed [71:0] rd;
    logic [62:0]        ypre;
    logic [63:0]        yp;
    logic signed [33:0] ps;
    if (en) begin
      pvs = 66'(f_pv_r[0]) + 66'(f_pv_r[1]) + 66'(f_pv_r[2]);
      rd  = rnd_sh(72'(pvs), 7'd30);
      g_dot_r <= rd[33:0];
      for (int i = 0; i < 3; i++) begin
        // Stage F: signed normal and products
        nq = $signed({1'b0, quo[i]});
        nq = dly_r[SIDE_LAT-1].dneg[i] ? -nq : nq;
        f_n_r[i]  <= nq;
        f_pv_r[i] <= $signed(dly_r[SIDE_LAT-1].vel[i]) * nq;
        f_pm_r[i] <= 62'(dly_r[SIDE_LAT-1].rad) * 62'(quo[i]);
        // Stage G: dot rounding and push pre-divide
        g_n_r[i] <= f_n_r[i];
        ypre = 63'(f_pm_r[i]) + (63'(5) << 30);
        g_y_r[i] <= 32'(ypre >> 30);
        // Stage H: reflection product and push divide by ten
        h_dn_r[i] <= g_dot_r * g_n_r[i];
        yp = 64'(g_y_r[i]) * 64'(RECIP10);
        h_push_r[i] <= 32'(yp >> RECIP10_SH);
        // Stage I: reflected velocity and pushed position
        rd = rnd_sh(72'(h_dn_r[i]), 7'd29);
        ps = h_s_r.dneg[i] ? -$signed({2'b00, h_push_r[i]}) : $signed({2'b00, h_push_r[i]});
        if (h_s_r.nz) begin
          i_v2_r[i] <= 36'($signed(h_s_r.vel[i])) - rd[35:0];
          i_np_r[i] <= 34'($signed(h_s_r.pos[i])) + ps;
        end else begin
          i_v2_r[i] <= 36'($signed(h_s_r.vel[i]));
          i_np_r[i] <= 34'($signed(h_s_r.pos[i]));
        end
        // Stage J: elasticity scale
        j_ve_r[i] <= i_v2_r[i] * $signed({1'b0, elas_r});
        j_np_r[i] <= i_np_r[i];
      end
    end
  end

  // Output register: round, saturate, select bounced or unchanged
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= j_s_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [71:0] nv;
    if (en) begin
      ohit_r <= j_s_r.hit;
      for (int i = 0; i < 3; i++) begin
        nv = rnd_sh(72'(j_ve_r[i]), 7'd16);
        if (j_s_r.hit && (i < DIM)) begin
          opos_r[i] <= sat32(72'(j_np_r[i]));
          ovel_r[i] <= sat32(nv);
        end else begin
          opos_r[i] <= j_s_r.pos[i];
          ovel_r[i] <= j_s_r.vel[i];
        end
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = ohit_r;
  assign out_new_pos_x = opos_r[0];
  assign out_new_pos_y = opos_r[1];
  assign out_new_pos_z = opos_r[2];
  assign out_new_vel_x = ovel_r[0];
  assign out_new_vel_y = ovel_r[1];
  assign out_new_vel_z = ovel_r[2];

endmodule
`default_nettype wire

// File: src/scr_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module scr_isqrt (
  input  wire                         clk,
  input  wire                         en,
  input  wire  [scr_pkg::SQ_W-1:0]    x,
  output logic [scr_pkg::ROOT_W-1:0]  root
);
  import scr_pkg::*;

  logic [SQ_W-1:0] x_r   [ISQ_STEPS];
  logic [SQ_W-1:0] res_r [ISQ_STEPS];
  logic [SQ_W-1:0] x_nxt   [ISQ_STEPS];
  logic [SQ_W-1:0] res_nxt [ISQ_STEPS];

  // One digit-by-digit step per stage; the trial bit is fixed per stage
  always_comb begin
    logic [SQ_W-1:0] xi;
    logic [SQ_W-1:0] ri;
    logic [SQ_W-1:0] bt;
    for (int k = 0; k < ISQ_STEPS; k++) begin
      xi = (k == 0) ? x : x_r[(k == 0) ? 0 : k - 1];
      ri = (k == 0) ? '0 : res_r[(k == 0) ? 0 : k - 1];
      bt = SQ_W'(1) << (SQ_W - 2 - 2 * k);
      if (xi >= ri + bt) begin
        x_nxt[k]   = xi - (ri + bt);
        res_nxt[k] = (ri >> 1) + bt;
      end else begin
        x_nxt[k]   = xi;
        res_nxt[k] = ri >> 1;
      end
    end
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ISQ_STEPS; k++) begin
        x_r[k]   <= x_nxt[k];
        res_r[k] <= res_nxt[k];
      end
    end
  end

  assign root = res_r[ISQ_STEPS-1][ROOT_W-1:0];

endmodule
`default_nettype wire

// File: src/scr_div.sv
// Pipelined restoring divider: (num << 30) / den, one quotient bit per stage.
`default_nettype none
module scr_div (
  input  wire                         clk,
  input  wire                         en,
  input  wire  [scr_pkg::MN_W-1:0]    num,
  input  wire  [scr_pkg::ROOT_W-1:0]  den,
  output logic [scr_pkg::MN_W-1:0]    quo
);
  import scr_pkg::*;

  logic [ROOT_W-1:0] rem_r [DIV_STEPS];
  logic [ROOT_W-1:0] den_r [DIV_STEPS];
  logic [MN_W-1:0]   q_r   [DIV_STEPS];
  logic [ROOT_W-1:0] rem_nxt [DIV_STEPS];
  logic [MN_W-1:0]   q_nxt   [DIV_STEPS];
  logic [ROOT_W-1:0] den_nxt [DIV_STEPS];

  // First stage sees the whole numerator top; later stages shift in zeros
  always_comb begin
    logic [ROOT_W:0] t;
    logic            ge;
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (j == 0) begin
        t          = (ROOT_W + 1)'(num);
        den_nxt[j] = den;
        q_nxt[j]   = '0;
      end else begin
        t          = {rem_r[(j == 0) ? 0 : j - 1], 1'b0};
        den_nxt[j] = den_r[(j == 0) ? 0 : j - 1];
        q_nxt[j]   = q_r[(j == 0) ? 0 : j - 1];
      end
      ge = (t >= {1'b0, den_nxt[j]});
      rem_nxt[j] = ge ? ROOT_W'(t - {1'b0, den_nxt[j]}) : ROOT_W'(t);
      q_nxt[j][DIV_STEPS-1-j] = ge;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < DIV_STEPS; j++) begin
        rem_r[j] <= rem_nxt[j];
        den_r[j] <= den_nxt[j];
        q_r[j]   <= q_nxt[j];
      end
    end
  end

  assign quo = q_r[DIV_STEPS-1];

endmodule
`default_nettype wire

// File: src/scr_checker.sv
// Port-level checks of the sphere collision block and their binding.
`default_nettype none
module scr_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_new_pos_x,
  input wire [31:0] out_new_vel_x,
  input wire        out_hit
);

  // Reset empties the output
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat valid after reset");

  // Stalled beat stays valid
  a_hold_vld: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  // Stalled beat keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_new_pos_x) && $stable(out_new_vel_x) && $stable(out_hit))
    else $error("output payload changed while stalled");

  // A stalled output freezes the pipeline input
  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline frozen");

  // An empty output slot lets the pipeline advance
  a_free_in: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused with free output slot");

endmodule

bind sphere_collision_response scr_checker u_scr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_new_pos_x (out_new_pos_x),
  .out_new_vel_x (out_new_vel_x),
  .out_hit       (out_hit)
);
`default_nettype wire

// File: verif/tb_sphere_collision_response.sv
// Testbench for the sphere collision block: directed table plus random particles.
`timescale 1ns / 1ps
`default_nettype none
module tb_sphere_collision_response;
  import scr_pkg::*;

  localparam int LATENCY   = 74;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 1500;

  typedef struct {
    logic [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
    logic [30:0] rad;
  } particle_t;

  typedef struct {
    logic [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
    logic        hit;
  } bounce_t;

  // Directed row: optional typed expectation
  typedef struct {
    particle_t p;
    logic      fixed;
    bounce_t   b;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [31:0] in_vel_x = '0, in_vel_y = '0, in_vel_z = '0;
  logic [30:0] in_node_radius = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_new_pos_x, out_new_pos_y, out_new_pos_z;
  logic [31:0] out_new_vel_x, out_new_vel_y, out_new_vel_z;
  logic out_hit;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Predictor copy of the registers
  logic signed [63:0] sph_c [3];
  logic [63:0] sph_r;
  logic [63:0] sph_e;

  bounce_t bounce_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  sphere_collision_response u_top (.*);

  always #1 clk = ~clk;

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  // Round x / 2^s to nearest, ties away from zero
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] x, input int s);
    logic [63:0] m;
    m = (mag64(x) + (64'd1 << (s - 1))) >> s;
    return x < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'h7FFFFFFF;
    if (x < -64'sd2147483648) return 32'h80000000;
    return x[31:0];
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Compute the bounced particle
  function automatic bounce_t bounce(input particle_t p);
    logic signed [63:0] pos [3], vel [3], d [3], nrm [3];
    logic [63:0] m [3];
    logic [63:0] lo, sq, maxm, rr, sum, len, pm;
    logic signed [63:0] dot, v2;
    int hi, sh;
    bit hit, has_n;
    bounce_t b;
    pos[0] = $signed(p.pos_x); pos[1] = $signed(p.pos_y); pos[2] = $signed(p.pos_z);
    vel[0] = $signed(p.vel_x); vel[1] = $signed(p.vel_y); vel[2] = $signed(p.vel_z);
    lo = 0; hi = 0; maxm = 0; has_n = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = pos[i] - sph_c[i];
      m[i] = mag64(d[i]);
      nrm[i] = 0;
    end
    for (int i = 0; i < DIM; i++) begin
      sq = m[i] * m[i];
      lo += sq;
      if (lo < sq) hi++;
      if (m[i] > maxm) maxm = m[i];
    end
    rr = (sph_r + 64'(p.rad)) * (sph_r + 64'(p.rad));
    hit = (hi == 0 && lo <= rr);
    if (hit && maxm != 0) begin
      sh = 0;
      while ((maxm >> sh) >= (64'd1 << 31)) sh++;
      if (sh > 0) begin
        for (int i = 0; i < DIM; i++) m[i] >>= sh;
      end else begin
        while ((maxm << sh) < (64'd1 << 30)) sh++;
        for (int i = 0; i < DIM; i++) m[i] <<= sh;
      end
      sum = 0;
      for (int i = 0; i < DIM; i++) sum += m[i] * m[i];
      len = floor_sqrt(sum);
      for (int i = 0; i < DIM; i++) begin
        nrm[i] = $signed((m[i] << 30) / len);
        if (d[i] < 0) nrm[i] = -nrm[i];
      end
      has_n = 1;
    end
    if (hit) begin
      dot = 0;
      if (has_n) begin
        for (int i = 0; i < DIM; i++) dot += vel[i] * nrm[i];
        dot = round_shift(dot, 30);
      end
      for (int i = 0; i < DIM; i++) begin
        v2 = vel[i];
        if (has_n) begin
          v2 -= round_shift(dot * nrm[i], 29);
          pm = 64'(p.rad) * mag64(nrm[i]);
          pm = (pm + (64'd5 << 30)) / (64'd10 << 30);
          pos[i] += nrm[i] < 0 ? -$signed(pm) : $signed(pm);
        end
        vel[i] = round_shift(v2 * $signed(sph_e), 16);
      end
    end
    b.pos_x = clamp32(pos[0]); b.pos_y = clamp32(pos[1]); b.pos_z = clamp32(pos[2]);
    b.vel_x = clamp32(vel[0]); b.vel_y = clamp32(vel[1]); b.vel_z = clamp32(vel[2]);
    b.hit = hit;
    return b;
  endfunction

  // Wait until a beat is taken on the input channel; valid stays up for a following beat
  task automatic send_particle(input particle_t p, input logic fixed, input bounce_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_pos_x <= p.pos_x; in_pos_y <= p.pos_y; in_pos_z <= p.pos_z;
    in_vel_x <= p.vel_x; in_vel_y <= p.vel_y; in_vel_z <= p.vel_z;
    in_node_radius <= p.rad;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bounce_q.push_back(fixed ? b : bounce(p));
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_CENTER_X, CFG_CENTER_Y, CFG_CENTER_Z: sph_c[int'(idx)] = $signed(val);
      CFG_RADIUS:     sph_r = 64'(val[30:0]);
      CFG_ELASTICITY: sph_e = 64'(val[17:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (bounce_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord(input logic [31:0] base, input int spread);
    return base + 32'($signed($urandom_range(2 * spread)) - spread);
  endfunction

  // Random particle, mostly near the sphere so that hits are common
  function automatic particle_t rand_particle();
    particle_t p;
    int k;
    k = $urandom_range(9);
    p.rad = 31'($urandom_range(3 * 65536));
    if (k < 6) begin
      p.pos_x = rand_coord(sph_c[0][31:0], 3 * 65536);
      p.pos_y = rand_coord(sph_c[1][31:0], 3 * 65536);
      p.pos_z = rand_coord(sph_c[2][31:0], 3 * 65536);
    end else if (k < 7) begin
      p.pos_x = rand_coord(sph_c[0][31:0], 8);
      p.pos_y = rand_coord(sph_c[1][31:0], 8);
      p.pos_z = rand_coord(sph_c[2][31:0], 8);
    end else begin
      p.pos_x = $urandom; p.pos_y = $urandom; p.pos_z = $urandom;
      p.rad = 31'($urandom);
    end
    p.vel_x = $urandom_range(3) == 0 ? $urandom : rand_coord(0, 20 * 65536);
    p.vel_y = $urandom_range(3) == 0 ? $urandom : rand_coord(0, 20 * 65536);
    p.vel_z = $urandom_range(3) == 0 ? $urandom : rand_coord(0, 20 * 65536);
    return p;
  endfunction

  function automatic particle_t mk(input logic [31:0] px, py, pz, vx, vy, vz,
                                   input logic [30:0] r);
    particle_t p;
    p.pos_x = px; p.pos_y = py; p.pos_z = pz;
    p.vel_x = vx; p.vel_y = vy; p.vel_z = vz;
    p.rad = r;
    return p;
  endfunction

  function automatic bounce_t mkb(input logic [31:0] px, py, pz, vx, vy, vz,
                                  input logic h);
    bounce_t b;
    b.pos_x = px; b.pos_y = py; b.pos_z = pz;
    b.vel_x = vx; b.vel_y = vy; b.vel_z = vz;
    b.hit = h;
    return b;
  endfunction

  // Receiver: stall at random, or hold off for a long stretch
  always @(negedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    bounce_t e;
    if (rst_n && out_valid && out_ready) begin
      if (bounce_q.size() == 0) begin
        $display("%0t: unexpected result beat", $time);
        errors++;
      end else begin
        e = bounce_q.pop_front();
        if ({out_new_pos_x, out_new_pos_y, out_new_pos_z, out_new_vel_x, out_new_vel_y,
             out_new_vel_z, out_hit} !== {e.pos_x, e.pos_y, e.pos_z, e.vel_x, e.vel_y,
             e.vel_z, e.hit}) begin
          $display("%0t: mismatch exp pos %h %h %h vel %h %h %h hit %b", $time,
                   e.pos_x, e.pos_y, e.pos_z, e.vel_x, e.vel_y, e.vel_z, e.hit);
          $display("%0t:          got pos %h %h %h vel %h %h %h hit %b", $time,
                   out_new_pos_x, out_new_pos_y, out_new_pos_z, out_new_vel_x,
                   out_new_vel_y, out_new_vel_z, out_hit);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Long receiver hold-off while the sender keeps offering
  task automatic pressure_burst();
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        repeat (150) send_particle(rand_particle(), 1'b0, '{default: '0});
      end
    join
  endtask

  initial begin
    row_t rows[$];
    bounce_t nob;
    int phase;
    nob = '{default: '0};
    sph_c[0] = 0; sph_c[1] = 0; sph_c[2] = 0;
    sph_r = 65536; sph_e = 65536;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows at reset settings (unit sphere at origin, elasticity 1.0)
    rows.push_back('{mk(0, 0, 0, 32'h10000, 32'hFFFF0000, 5, 0), 1,
                     mkb(0, 0, 0, 32'h10000, 32'hFFFF0000, 5, 1)});
    rows.push_back('{mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 7, 8, 9, 0), 1,
                     mkb(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 7, 8, 9, 0)});
    rows.push_back('{mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                        32'h7FFFFFFF, 0, 31'h7FFFFFFF), 0, nob});
    rows.push_back('{mk(32'h8000, 0, 0, 32'hFFFF0000, 0, 0, 0), 0, nob});
    rows.push_back('{mk(0, 32'hFFFF8000, 0, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                        31'h7FFFFFFF), 0, nob});
    rows.push_back('{mk(32'h10000, 0, 0, 32'hFFFE0000, 0, 0, 0), 0, nob});
    rows.push_back('{mk(32'h10001, 0, 0, 1, 1, 1, 0), 1, mkb(32'h10001, 0, 0, 1, 1, 1, 0)});
    rows.push_back('{mk(32'h20000, 0, 0, 3, 0, 0, 31'h10000), 0, nob});
    rows.push_back('{mk(1, 1, 1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF),
                     0, nob});
    rows.push_back('{mk(32'h9000, 32'h9000, 32'h9000, 32'h12345, 32'hFFFEDCBA, 77,
                        31'h4000), 0, nob});
    foreach (rows[i]) send_particle(rows[i].p, rows[i].fixed, rows[i].b);
    drain();

    // Extreme settings: elasticity max, radius max, centre x and y at extremes
    write_reg(CFG_ELASTICITY, 32'h3FFFF);
    write_reg(CFG_RADIUS, 32'h7FFFFFFF);
    write_reg(CFG_CENTER_X, 32'h80000000);
    write_reg(CFG_CENTER_Y, 32'h7FFFFFFF);
    write_reg(CFG_CENTER_Z, 32'h0);
    send_particle(mk(32'h80000000, 32'h7FFFFFFF, 0, 32'h80000000, 32'h7FFFFFFF, 3, 5),
                  0, nob);
    send_particle(mk(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h40000000,
                     32'hC0000000, 1, 31'h7FFFFFFF), 0, nob);
    send_particle(mk(0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF),
                  0, nob);
    drain();
    // Zero elasticity and zero radius
    write_reg(CFG_ELASTICITY, 0);
    write_reg(CFG_RADIUS, 0);
    send_particle(mk(32'h80000000, 32'h7FFFFFFF, 0, 9, 9, 9, 0), 1,
                  mkb(32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0, 1));
    send_particle(mk(32'h80000001, 32'h7FFFFFFF, 0, 9, 9, 9, 1), 0, nob);
    drain();

    // Random phases, each under new settings and idling mix
    for (phase = 0; phase < 6; phase++) begin
      write_reg(CFG_CENTER_X, rand_coord(0, 50 * 65536));
      write_reg(CFG_CENTER_Y, rand_coord(0, 50 * 65536));
      write_reg(CFG_CENTER_Z, phase == 5 ? $urandom : rand_coord(0, 50 * 65536));
      write_reg(CFG_RADIUS, $urandom_range(4 * 65536));
      write_reg(CFG_ELASTICITY, $urandom_range(131072));
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      if (phase == 2) pressure_burst();
      repeat (N_RANDOM / 6) send_particle(rand_particle(), 1'b0, nob);
      drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
src/scr_pkg.sv
src/scr_isqrt.sv
src/scr_div.sv
src/sphere_collision_response.sv
src/scr_checker.sv
verif/tb_sphere_collision_response.sv
